// ===== hdl/svf_lp_pkg.sv =====
// ============================================================================
// svf_lp_pkg: shared definitions for the saturating lowpass state-variable filter
// Formats, constants, microcode word layout and the microcode program.
// ============================================================================
package svf_lp_pkg;

    // Fixed formats of the datapath.
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 24;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 1;
    localparam int STATE_BITS     = 32;
    localparam int INT_FRAC       = 24;
    localparam int BAND_BITS      = INT_FRAC + 2;
    localparam int X_SHIFT        = INT_FRAC - (SAMPLE_BITS - 1);
    localparam int X_BITS         = SAMPLE_BITS + X_SHIFT;
    localparam int V3_BITS        = STATE_BITS + 1;
    localparam int ACC_W          = 40;
    localparam int WIDE_W         = ACC_W + 2;

    // Shared multiplier and limiter divider.
    localparam int MUL_A_W       = 32;
    localparam int MUL_B_W       = 30;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int LIM_MAG_BITS  = INT_FRAC + 2;
    localparam int X2_BITS       = INT_FRAC + 4;
    localparam int T_BITS        = INT_FRAC + 6;
    localparam int DEN_BITS      = INT_FRAC + 7;
    localparam int DIVIDEND_BITS = INT_FRAC + 32;
    localparam int QUO_BITS      = INT_FRAC + 1;
    localparam int CNT_BITS      = $clog2(QUO_BITS);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(QUO_BITS - 1);

    // Configuration register map.
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_A1 = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_A2 = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_A3 = 2'd2;
    localparam logic [COEF_BITS-1:0] A1_RESET = COEF_BITS'(6743099);
    localparam logic [COEF_BITS-1:0] A2_RESET = COEF_BITS'(3893153);
    localparam logic [COEF_BITS-1:0] A3_RESET = COEF_BITS'(2247643);

    // Arithmetic constants.
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam longint unsigned K27 = 27 * (64'd1 << INT_FRAC);
    localparam logic signed [WIDE_W-1:0] LIM_POS = WIDE_W'(3 * (64'sd1 <<< INT_FRAC));
    localparam logic signed [WIDE_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [BAND_BITS-1:0] BAND_ONE = BAND_BITS'(64'sd1 <<< INT_FRAC);
    localparam logic signed [BAND_BITS-1:0] BAND_MINUS_ONE = -BAND_ONE;
    localparam logic signed [WIDE_W-1:0] LOW_MAX =
        {{(WIDE_W - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] LOW_MIN =
        {{(WIDE_W - STATE_BITS + 1){1'b1}}, {(STATE_BITS - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] OUT_MAX_ACC =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] OUT_MIN_ACC =
        {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MAX_CODE = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MIN_CODE = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Microcode word fields.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_BAND_A1,
        MUL_V3_A2,
        MUL_BAND_A2,
        MUL_V3_A3,
        MUL_M_M,
        MUL_M_T
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_ZERO,
        ACC_ADD,
        ACC_LOW_ADD
    } acc_op_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_V3,
        OP_SAVE_LIM,
        OP_STATE_OUT,
        OP_LIM_CHECK,
        OP_SQUARE,
        OP_DEN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_BAND_WRITE
    } dp_op_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT,
        SEQ_IF_SAT,
        SEQ_LOOP,
        SEQ_JUMP
    } seq_t;

    localparam int STEP_BITS = 4;
    typedef logic [STEP_BITS-1:0] step_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        dp_op_t   dp_op;
        seq_t     seq;
        step_t    target;
    } uword_t;

    // Program addresses.
    localparam step_t STEP_WAIT     = 4'd0;
    localparam step_t STEP_V3       = 4'd1;
    localparam step_t STEP_MUL_B1   = 4'd2;
    localparam step_t STEP_MUL_V2   = 4'd3;
    localparam step_t STEP_MUL_B2   = 4'd4;
    localparam step_t STEP_MUL_V3   = 4'd5;
    localparam step_t STEP_ACC_V2   = 4'd6;
    localparam step_t STEP_STATE    = 4'd7;
    localparam step_t STEP_LIM      = 4'd8;
    localparam step_t STEP_SQ_MUL   = 4'd9;
    localparam step_t STEP_SQ       = 4'd10;
    localparam step_t STEP_NUM      = 4'd11;
    localparam step_t STEP_DIV_INIT = 4'd12;
    localparam step_t STEP_DIV      = 4'd13;
    localparam step_t STEP_BAND     = 4'd14;

    // Microcode program. Products are registered in the product register, so
    // each product is accumulated in the step after the one that starts it.
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        w = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, dp_op: OP_NONE,
              seq: SEQ_NEXT, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT: begin
                w.seq = SEQ_WAIT_IN;
            end
            STEP_V3: begin
                w.dp_op  = OP_V3;
                w.acc_op = ACC_ZERO;
            end
            STEP_MUL_B1: begin
                w.mul_sel = MUL_BAND_A1;
            end
            STEP_MUL_V2: begin
                w.mul_sel = MUL_V3_A2;
                w.acc_op  = ACC_ADD;
            end
            STEP_MUL_B2: begin
                w.mul_sel = MUL_BAND_A2;
                w.acc_op  = ACC_ADD;
            end
            STEP_MUL_V3: begin
                w.mul_sel = MUL_V3_A3;
                w.acc_op  = ACC_LOW_ADD;
                w.dp_op   = OP_SAVE_LIM;
            end
            STEP_ACC_V2: begin
                w.acc_op = ACC_ADD;
            end
            STEP_STATE: begin
                w.dp_op = OP_STATE_OUT;
                w.seq   = SEQ_WAIT_OUT;
            end
            STEP_LIM: begin
                w.dp_op  = OP_LIM_CHECK;
                w.seq    = SEQ_IF_SAT;
                w.target = STEP_WAIT;
            end
            STEP_SQ_MUL: begin
                w.mul_sel = MUL_M_M;
            end
            STEP_SQ: begin
                w.dp_op = OP_SQUARE;
            end
            STEP_NUM: begin
                w.mul_sel = MUL_M_T;
                w.dp_op   = OP_DEN;
            end
            STEP_DIV_INIT: begin
                w.dp_op = OP_DIV_INIT;
            end
            STEP_DIV: begin
                w.dp_op  = OP_DIV_STEP;
                w.seq    = SEQ_LOOP;
                w.target = STEP_DIV;
            end
            STEP_BAND: begin
                w.dp_op  = OP_BAND_WRITE;
                w.seq    = SEQ_JUMP;
                w.target = STEP_WAIT;
            end
            default: begin
                w.seq    = SEQ_JUMP;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/saturating_svf_lowpass_unit.sv =====
// ============================================================================
// saturating_svf_lowpass_unit: saturating state-variable lowpass filter
// Trapezoidal state-variable filter with a soft-limited band state, run by a
// microcoded sequencer over one shared multiplier and a restoring divider.
// ============================================================================
//
// Usage:
// - Input stream: s_tdata carries one signed sample, s_tuser clears both
//   integrator states before that sample is filtered.
// - Output stream: m_tdata carries the saturated lowpass sample, m_tuser
//   flags that the sample was clipped. One output per input, in order.
// - Coefficients are written through cfg_wr_en/cfg_addr/cfg_wdata while the
//   filter is idle; unknown indexes are ignored.
// - The output register loads at the state-update step, before the limiter.
// - A new sample is taken only back at the first step: after the 25 iterations
//   of the bit-serial divider in the band limiter, or, when the limiter clamps,
//   straight after the limit check, with the divider skipped.
// - s_tready is high only while the program waits at its first step.
// - If the receiver stalls, the program holds at its state-update step
//   until the output register is free; the pending output stays stable.
// - Reset (aresetn low, synchronous) zeroes both states, loads the default
//   coefficients, empties the output register and restarts the program.
//
module saturating_svf_lowpass_unit (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Input stream.
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [svf_lp_pkg::SAMPLE_BITS-1:0]        s_tdata,   // [23:0] sample_in
    input  logic                                      s_tuser,   // [0] clear_state
    // Output stream.
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [svf_lp_pkg::SAMPLE_BITS-1:0]        m_tdata,   // [23:0] lowpass_out
    output logic                                      m_tuser,   // [0] clipped
    // Coefficient writes.
    input  logic                                      cfg_wr_en,
    input  logic [svf_lp_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
    input  logic [svf_lp_pkg::COEF_BITS-1:0]          cfg_wdata
);
    import svf_lp_pkg::*;

    // Sequencer and control registers.
    step_t                        step_reg, step_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    uword_t                       uw;

    // Coefficients and filter state.
    logic [COEF_BITS-1:0]         coef_a1_reg, coef_a1_next;
    logic [COEF_BITS-1:0]         coef_a2_reg, coef_a2_next;
    logic [COEF_BITS-1:0]         coef_a3_reg, coef_a3_next;
    logic signed [BAND_BITS-1:0]  band_reg, band_next;
    logic signed [STATE_BITS-1:0] low_reg, low_next;

    // Datapath registers.
    logic signed [X_BITS-1:0]     x_reg, x_next;
    logic signed [V3_BITS-1:0]    v3_reg, v3_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic                         prod_neg_reg, prod_neg_next;
    logic signed [WIDE_W-1:0]     lim_reg, lim_next;
    logic [LIM_MAG_BITS-1:0]      mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic [X2_BITS-1:0]           x2_reg, x2_next;
    logic [DEN_BITS-1:0]          den_reg, den_next;
    logic [DEN_BITS-1:0]          rem_reg, rem_next;
    logic [QUO_BITS-1:0]          quo_reg, quo_next;
    logic [SAMPLE_BITS-1:0]       m_tdata_reg, m_tdata_next;
    logic                         m_tuser_reg, m_tuser_next;

    // Combinational datapath signals.
    logic                         s_fire;
    logic                         out_free;
    logic                         lim_hi, lim_lo, lim_sat;
    logic signed [BAND_BITS-1:0]  band_abs;
    logic signed [V3_BITS-1:0]    v3_abs;
    logic signed [WIDE_W-1:0]     lim_abs;
    logic [MUL_A_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]           mul_b;
    logic                         mul_neg;
    logic [T_BITS-1:0]            t_val;
    logic [PROD_W-1:0]            rnd_sum;
    logic signed [ACC_W-1:0]      rp_pos;
    logic signed [ACC_W-1:0]      rp_val;
    logic signed [WIDE_W-1:0]     low_wide;
    logic signed [ACC_W:0]        y_sum;
    logic signed [ACC_W-1:0]      y_round;
    logic                         clip_hi, clip_lo;
    logic [DIVIDEND_BITS-1:0]     dividend;
    logic [DEN_BITS:0]            trial;
    logic [DEN_BITS:0]            diff;
    logic                         div_ge;

    assign uw       = ucode_rom(step_reg);
    assign s_tready = (step_reg == STEP_WAIT);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Limiter range test on the new band value.
    assign lim_hi  = lim_reg > LIM_POS;
    assign lim_lo  = lim_reg < LIM_NEG;
    assign lim_sat = lim_hi || lim_lo;

    // Magnitudes for the unsigned multiplier.
    assign band_abs = band_reg[BAND_BITS-1] ? -band_reg : band_reg;
    assign v3_abs   = v3_reg[V3_BITS-1] ? -v3_reg : v3_reg;
    assign lim_abs  = lim_reg[WIDE_W-1] ? -lim_reg : lim_reg;
    assign t_val    = T_BITS'(K27) + T_BITS'(x2_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (uw.mul_sel)
            MUL_BAND_A1: begin
                mul_a   = MUL_A_W'(band_abs[BAND_BITS-1:0]);
                mul_b   = MUL_B_W'(coef_a1_reg);
                mul_neg = band_reg[BAND_BITS-1];
            end
            MUL_V3_A2: begin
                mul_a   = v3_abs[MUL_A_W-1:0];
                mul_b   = MUL_B_W'(coef_a2_reg);
                mul_neg = v3_reg[V3_BITS-1];
            end
            MUL_BAND_A2: begin
                mul_a   = MUL_A_W'(band_abs[BAND_BITS-1:0]);
                mul_b   = MUL_B_W'(coef_a2_reg);
                mul_neg = band_reg[BAND_BITS-1];
            end
            MUL_V3_A3: begin
                mul_a   = v3_abs[MUL_A_W-1:0];
                mul_b   = MUL_B_W'(coef_a3_reg);
                mul_neg = v3_reg[V3_BITS-1];
            end
            MUL_M_M: begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MUL_B_W'(mag_reg);
            end
            MUL_M_T: begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = t_val;
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // Coefficient product rounded to nearest, ties away from zero.
    assign rnd_sum = prod_reg + ROUND_HALF;
    assign rp_pos  = $signed(ACC_W'(rnd_sum[PROD_W-1:COEF_FRAC_BITS]));
    assign rp_val  = prod_neg_reg ? -rp_pos : rp_pos;

    // New low state and rounded output from the lowpass value in the accumulator.
    assign low_wide = (WIDE_W'(acc_reg) <<< 1) - WIDE_W'(low_reg);
    assign y_sum    = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(1);
    assign y_round  = $signed(y_sum[ACC_W:1]);
    assign clip_hi  = y_round > OUT_MAX_ACC;
    assign clip_lo  = y_round < OUT_MIN_ACC;

    // Limiter division: rounding offset and one restoring step.
    assign dividend = prod_reg[DIVIDEND_BITS-1:0] + DIVIDEND_BITS'(den_reg >> 1);
    assign trial    = {rem_reg, quo_reg[QUO_BITS-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign div_ge   = trial >= {1'b0, den_reg};

    // Sequencer: next program step.
    always_comb begin
        step_next = step_reg;
        unique case (uw.seq)
            SEQ_NEXT:     step_next = step_t'(step_reg + 1'b1);
            SEQ_WAIT_IN:  step_next = s_fire ? step_t'(step_reg + 1'b1) : step_reg;
            SEQ_WAIT_OUT: step_next = out_free ? step_t'(step_reg + 1'b1) : step_reg;
            SEQ_IF_SAT:   step_next = lim_sat ? uw.target : step_t'(step_reg + 1'b1);
            SEQ_LOOP:     step_next = (cnt_reg != '0) ? uw.target : step_t'(step_reg + 1'b1);
            SEQ_JUMP:     step_next = uw.target;
            default:      step_next = STEP_WAIT;
        endcase
    end

    // Datapath: register updates driven by the control word.
    always_comb begin
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        coef_a1_next  = coef_a1_reg;
        coef_a2_next  = coef_a2_reg;
        coef_a3_next  = coef_a3_reg;
        band_next     = band_reg;
        low_next      = low_reg;
        x_next        = x_reg;
        v3_next       = v3_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        prod_neg_next = prod_neg_reg;
        lim_next      = lim_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        x2_next       = x2_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // Coefficient writes.
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_COEF_A1: coef_a1_next = cfg_wdata;
                REG_COEF_A2: coef_a2_next = cfg_wdata;
                REG_COEF_A3: coef_a3_next = cfg_wdata;
                default:     coef_a1_next = coef_a1_reg;
            endcase
        end

        // Sample capture, with an optional state clear.
        if (s_fire) begin
            x_next = $signed({s_tdata, {X_SHIFT{1'b0}}});
            if (s_tuser) begin
                band_next = '0;
                low_next  = '0;
            end
        end

        // Output register empties once the transfer completes.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Shared multiplier.
        if (uw.mul_sel != MUL_NONE) begin
            prod_next     = PROD_W'(mul_a) * PROD_W'(mul_b);
            prod_neg_next = mul_neg;
        end

        // Accumulator.
        case (uw.acc_op)
            ACC_ZERO:    acc_next = '0;
            ACC_ADD:     acc_next = acc_reg + rp_val;
            ACC_LOW_ADD: acc_next = ACC_W'(low_reg) + rp_val;
            default:     acc_next = acc_reg;
        endcase

        // Remaining datapath operations.
        case (uw.dp_op)
            OP_V3: begin
                v3_next = V3_BITS'(x_reg) - V3_BITS'(low_reg);
            end
            OP_SAVE_LIM: begin
                lim_next = (WIDE_W'(acc_reg) <<< 1) - WIDE_W'(band_reg);
            end
            OP_STATE_OUT: begin
                if (out_free) begin
                    if (low_wide > LOW_MAX) begin
                        low_next = $signed(LOW_MAX[STATE_BITS-1:0]);
                    end else if (low_wide < LOW_MIN) begin
                        low_next = $signed(LOW_MIN[STATE_BITS-1:0]);
                    end else begin
                        low_next = $signed(low_wide[STATE_BITS-1:0]);
                    end
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = clip_hi || clip_lo;
                    if (clip_hi) begin
                        m_tdata_next = OUT_MAX_CODE;
                    end else if (clip_lo) begin
                        m_tdata_next = OUT_MIN_CODE;
                    end else begin
                        m_tdata_next = y_round[SAMPLE_BITS-1:0];
                    end
                end
            end
            OP_LIM_CHECK: begin
                if (lim_sat) begin
                    band_next = lim_lo ? BAND_MINUS_ONE : BAND_ONE;
                end
                mag_next = lim_abs[LIM_MAG_BITS-1:0];
                neg_next = lim_reg[WIDE_W-1];
            end
            OP_SQUARE: begin
                x2_next = prod_reg[INT_FRAC+X2_BITS-1:INT_FRAC];
            end
            OP_DEN: begin
                den_next = DEN_BITS'(K27) + (DEN_BITS'(x2_reg) << 3) + DEN_BITS'(x2_reg);
            end
            OP_DIV_INIT: begin
                rem_next = dividend[DIVIDEND_BITS-1:QUO_BITS];
                quo_next = dividend[QUO_BITS-1:0];
                cnt_next = DIV_LAST;
            end
            OP_DIV_STEP: begin
                rem_next = div_ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
                quo_next = {quo_reg[QUO_BITS-2:0], div_ge};
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_BAND_WRITE: begin
                band_next = neg_reg ? -$signed(BAND_BITS'(quo_reg))
                                    : $signed(BAND_BITS'(quo_reg));
            end
            default: begin
                v3_next = v3_reg;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_WAIT;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            coef_a1_reg  <= A1_RESET;
            coef_a2_reg  <= A2_RESET;
            coef_a3_reg  <= A3_RESET;
            band_reg     <= '0;
            low_reg      <= '0;
        end else begin
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            coef_a1_reg  <= coef_a1_next;
            coef_a2_reg  <= coef_a2_next;
            coef_a3_reg  <= coef_a3_next;
            band_reg     <= band_next;
            low_reg      <= low_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        v3_reg       <= v3_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
        lim_reg      <= lim_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        x2_reg       <= x2_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

endmodule

// ===== hdl/svf_lp_checker.sv =====
// ============================================================================
// svf_lp_checker: port-level checks for the saturating lowpass filter
// Watches the stream ports of the top level and is bound to it below.
// ============================================================================
module svf_lp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [svf_lp_pkg::SAMPLE_BITS-1:0] m_tdata,   // [23:0] lowpass_out
    input logic                               m_tuser    // [0] clipped
);
    import svf_lp_pkg::*;

    // One sample at a time: an input transfer closes the input side.
    ap_busy_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample was still in work");

    // A fresh output appears only while the filter is still busy with its sample.
    ap_output_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("output appeared while the filter was idle");

    // A clipped output sits on one of the two rails.
    ap_clip_on_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == OUT_MAX_CODE) || (m_tdata == OUT_MIN_CODE))
        else $error("clipped output not at a rail");

    // A stalled output transfer keeps its payload.
    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output changed");

endmodule

bind saturating_svf_lowpass_unit svf_lp_checker u_svf_lp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
